FILE: hw/rtl/vector_load_store_burst_sequencer_macros.svh
// assertion helpers for the sequencer back part
`ifndef VECTOR_LOAD_STORE_BURST_SEQUENCER_MACROS_SVH
`define VECTOR_LOAD_STORE_BURST_SEQUENCER_MACROS_SVH

// property that must hold at every edge out of reset
`define VLS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define VLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/vlsbs_pkg.sv
package vlsbs_pkg;

   localparam int QUEUE_DEPTH  = 8;
   localparam int BURST_TOKENS = 4;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int TOK_W        = $clog2(BURST_TOKENS + 1);
   localparam int TAG_W        = 3;
   localparam int BYTES_W      = 20;
   localparam int LIM_W        = 9;
   localparam int LIM_MIN      = 8;
   localparam int LIM_MAX      = 256;

   typedef enum logic [2:0] {
      OP_ENQ   = 3'd0,
      OP_TICK  = 3'd1,
      OP_RESP  = 3'd2,
      OP_DENY  = 3'd3,
      OP_GRANT = 3'd4,
      OP_NONE  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_ACCEPT = 3'd1,
      KIND_REJECT = 3'd2,
      KIND_BURST  = 3'd3,
      KIND_RETIRE = 3'd4
   } kind_type;

   localparam logic [1:0] CSR_MAX_BURST   = 2'd0;
   localparam logic [1:0] CSR_START_DELAY = 2'd1;
   localparam logic [1:0] CSR_END_DELAY   = 2'd2;

   typedef struct packed {
      op_type              op;
      logic [63:0]         base_addr;
      logic                is_store;
      logic [BYTES_W-1:0]  bytes;
      logic [15:0]         reg_offset;
      logic [TAG_W-1:0]    resp_tag;
   } item_type;

   typedef struct packed {
      kind_type            kind;
      logic [TAG_W-1:0]    slot_tag;
      logic [63:0]         burst_addr;
      logic [8:0]          burst_bytes;
      logic                burst_write;
      logic [BYTES_W-1:0]  burst_reg_offset;
      logic                last;
   } result_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

FILE: hw/rtl/vector_load_store_burst_sequencer.sv
// vector load/store burst sequencer. requests (enqueue, tick, burst response,
// burst denied, grant) are taken into a two-entry queue by the front part and
// carried out by the back part one per cycle while the result buffer has room.
// a tick can produce up to two results (a burst and a retire); those leave the
// result buffer one transfer per cycle while the output is not stalled, so a
// tick with two results holds the back part until its second result is taken.
// instruction slots, burst bookkeeping and the 32-bit tick clock all live in
// the back part; configuration writes are always ready and must only be done
// while the block is idle.
module vector_load_store_burst_sequencer import vlsbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_base_addr,
   input  logic        req_is_store,
   input  logic [15:0] req_elem_count,
   input  logic [2:0]  req_width_code,
   input  logic [15:0] req_reg_offset,
   input  logic [2:0]  req_resp_tag,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_slot_tag,
   output logic [63:0] rsp_burst_addr,
   output logic [8:0]  rsp_burst_bytes,
   output logic        rsp_burst_write,
   output logic [19:0] rsp_burst_reg_offset,
   output logic        rsp_last,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   logic       q_valid, q_pop;
   item_type   q_item;
   result_type res;

   // registers take a transfer in any cycle
   assign csr_ready = 1'b1;

   vlsbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_base_addr  (req_base_addr),
      .req_is_store   (req_is_store),
      .req_elem_count (req_elem_count),
      .req_width_code (req_width_code),
      .req_reg_offset (req_reg_offset),
      .req_resp_tag   (req_resp_tag),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   vlsbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (res)
   );

   // unpack the buffered result onto the ports
   assign rsp_kind             = res.kind;
   assign rsp_slot_tag         = res.slot_tag;
   assign rsp_burst_addr       = res.burst_addr;
   assign rsp_burst_bytes      = res.burst_bytes;
   assign rsp_burst_write      = res.burst_write;
   assign rsp_burst_reg_offset = res.burst_reg_offset;
   assign rsp_last             = res.last;

endmodule

FILE: hw/rtl/vlsbs_front.sv
module vlsbs_front import vlsbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_base_addr,
   input  logic        req_is_store,
   input  logic [15:0] req_elem_count,
   input  logic [2:0]  req_width_code,
   input  logic [15:0] req_reg_offset,
   input  logic [2:0]  req_resp_tag,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   dec;
   logic [1:0] shift;
   logic       push;

   // classify the request and size the transfer
   always_comb begin
      shift = (req_width_code >= 3'd5) ? 2'(req_width_code - 3'd4) : 2'd0;
      dec.base_addr  = req_base_addr;
      dec.is_store   = req_is_store;
      dec.bytes      = BYTES_W'(req_elem_count) << shift;
      dec.reg_offset = req_reg_offset;
      dec.resp_tag   = req_resp_tag;
      unique case (req_mode)
         OP_ENQ:   dec.op = OP_ENQ;
         OP_TICK:  dec.op = OP_TICK;
         OP_RESP:  dec.op = OP_RESP;
         OP_DENY:  dec.op = OP_DENY;
         OP_GRANT: dec.op = OP_GRANT;
         default:  dec.op = OP_NONE;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ q_pop;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= dec;
      end
   end

endmodule

FILE: hw/rtl/vlsbs_back.sv
`include "vector_load_store_burst_sequencer_macros.svh"

module vlsbs_back import vlsbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  item_type     q_item,
   output logic         q_pop,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output result_type   rsp_res
);

   logic [63:0]        saddr_ff [QUEUE_DEPTH];
   logic [BYTES_W-1:0] sbytes_ff [QUEUE_DEPTH];
   logic               swrite_ff [QUEUE_DEPTH];
   logic [15:0]        sroff_ff [QUEUE_DEPTH];
   logic [31:0]        ready_ff [QUEUE_DEPTH], ready_in [QUEUE_DEPTH];
   logic [2:0]         outst_ff [QUEUE_DEPTH], outst_in [QUEUE_DEPTH];
   logic               issued_ff [QUEUE_DEPTH], issued_in [QUEUE_DEPTH];
   logic [31:0]        age [QUEUE_DEPTH];
   logic               passed [QUEUE_DEPTH];

   logic [PTR_W-1:0]   head_ff, head_in, wait_ff, wait_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   occ_ff, occ_in, wcnt_ff, wcnt_in;
   logic [63:0]        caddr_ff, caddr_in;
   logic [BYTES_W-1:0] crem_ff, crem_in, croff_ff, croff_in;
   logic               stall_ff, stall_in;
   logic [TOK_W-1:0]   tok_ff, tok_in;
   logic [31:0]        tick_ff, tick_in;
   logic [8:0]         maxb_ff;
   logic [3:0]         sdly_ff, edly_ff;

   result_type         res_ff [2], res_in [2];
   logic [1:0]         rcnt_ff, rcnt_in;

   logic               xfer, enq_wr, resp_ok;
   logic [LIM_W-1:0]   lim, size;
   logic [PTR_W-1:0]   wp, rtag;
   logic [1:0]         n;
   result_type         nres [2];

   function automatic result_type mk(input kind_type k, input logic [TAG_W-1:0] t);
      result_type r;
      r = '0;
      r.kind = k;
      r.slot_tag = t;
      mk = r;
   endfunction

   assign xfer      = rsp_valid && !rsp_stall;
   assign rsp_valid = (rcnt_ff != 2'd0);
   assign rsp_res   = res_ff[0];
   assign q_pop     = q_valid && (rcnt_ff == 2'd0 || (rcnt_ff == 2'd1 && xfer));
   assign enq_wr    = q_pop && q_item.op == OP_ENQ && occ_ff != CNT_W'(QUEUE_DEPTH);
   assign rtag      = PTR_W'(q_item.resp_tag);
   assign resp_ok   = (int'(q_item.resp_tag) < QUEUE_DEPTH) && outst_ff[rtag] != 3'd0;

   always_comb begin
      lim = (maxb_ff < 9'(LIM_MIN)) ? LIM_W'(LIM_MIN) :
            (maxb_ff > 9'(LIM_MAX)) ? LIM_W'(LIM_MAX) : maxb_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         age[i]    = tick_ff - ready_ff[i];
         passed[i] = !age[i][31];
      end
   end

   always_comb begin
      ready_in  = ready_ff;
      outst_in  = outst_ff;
      issued_in = issued_ff;
      head_in   = head_ff;
      wait_in   = wait_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      wcnt_in   = wcnt_ff;
      caddr_in  = caddr_ff;
      crem_in   = crem_ff;
      croff_in  = croff_ff;
      stall_in  = stall_ff;
      tok_in    = tok_ff;
      tick_in   = tick_ff;
      nres[0]   = '0;
      nres[1]   = '0;
      n         = 2'd0;
      wp        = wait_ff;
      size      = '0;
      if (q_pop) begin
         unique case (q_item.op)
            OP_ENQ: begin
               n = 2'd1;
               if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
                  nres[0] = mk(KIND_REJECT, TAG_W'(tail_ff));
               end else begin
                  nres[0] = mk(KIND_ACCEPT, TAG_W'(tail_ff));
                  ready_in[tail_ff]  = tick_ff + 32'(sdly_ff);
                  outst_in[tail_ff]  = 3'd0;
                  issued_in[tail_ff] = 1'b0;
                  tail_in = ptr_next(tail_ff);
                  occ_in  = occ_ff + CNT_W'(1);
                  wcnt_in = wcnt_ff + CNT_W'(1);
               end
            end
            OP_TICK: begin
               // start the oldest waiting instruction
               if (wcnt_in != '0 && crem_in == '0 && passed[wp]) begin
                  caddr_in = saddr_ff[wp];
                  crem_in  = sbytes_ff[wp];
                  croff_in = BYTES_W'(sroff_ff[wp]);
                  if (crem_in == '0) begin
                     issued_in[wp] = 1'b1;
                     wp = ptr_next(wp);
                     if (wcnt_in != '0) wcnt_in = wcnt_in - CNT_W'(1);
                  end
               end
               // at most one burst per tick
               if (crem_in != '0 && tok_ff != '0 && !stall_ff) begin
                  size = (crem_in < BYTES_W'(lim)) ? LIM_W'(crem_in) : lim;
                  nres[0] = mk(KIND_BURST, TAG_W'(wp));
                  nres[0].burst_addr       = caddr_in;
                  nres[0].burst_bytes      = size;
                  nres[0].burst_write      = swrite_ff[wp];
                  nres[0].burst_reg_offset = croff_in;
                  n = 2'd1;
                  tok_in = tok_ff - TOK_W'(1);
                  outst_in[wp] = outst_in[wp] + 3'd1;
                  caddr_in = caddr_in + 64'(size);
                  crem_in  = crem_in - BYTES_W'(size);
                  croff_in = croff_in + BYTES_W'(size);
                  if (crem_in == '0) begin
                     issued_in[wp] = 1'b1;
                     wp = ptr_next(wp);
                     if (wcnt_in != '0) wcnt_in = wcnt_in - CNT_W'(1);
                  end
               end
               wait_in = wp;
               // in-order retire of the head
               if (occ_ff != '0 && outst_in[head_ff] == 3'd0 && issued_in[head_ff]
                   && passed[head_ff]) begin
                  nres[n[0]] = mk(KIND_RETIRE, TAG_W'(head_ff));
                  n = n + 2'd1;
                  issued_in[head_ff] = 1'b0;
                  head_in = ptr_next(head_ff);
                  occ_in  = occ_ff - CNT_W'(1);
               end
               tick_in = tick_ff + 32'd1;
            end
            OP_RESP: begin
               if (resp_ok) begin
                  outst_in[rtag] = outst_ff[rtag] - 3'd1;
                  if (tok_ff < TOK_W'(BURST_TOKENS)) tok_in = tok_ff + TOK_W'(1);
                  if (outst_in[rtag] == 3'd0) ready_in[rtag] = tick_ff + 32'(edly_ff);
               end
            end
            OP_DENY:  stall_in = 1'b1;
            OP_GRANT: stall_in = 1'b0;
            default: ;
         endcase
         if (n == 2'd2) nres[1].last = 1'b1;
         else if (n == 2'd1) nres[0].last = 1'b1;
      end
      // output buffer: load on pop, otherwise shift on transfer
      res_in  = res_ff;
      rcnt_in = rcnt_ff;
      if (q_pop) begin
         res_in  = nres;
         rcnt_in = n;
      end else if (xfer) begin
         res_in[0] = res_ff[1];
         rcnt_in   = rcnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            outst_ff[i]  <= 3'd0;
            issued_ff[i] <= 1'b0;
         end
         head_ff  <= '0;
         wait_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
         wcnt_ff  <= '0;
         caddr_ff <= '0;
         crem_ff  <= '0;
         croff_ff <= '0;
         stall_ff <= 1'b0;
         tok_ff   <= TOK_W'(BURST_TOKENS);
         tick_ff  <= '0;
         rcnt_ff  <= 2'd0;
         maxb_ff  <= 9'd16;
         sdly_ff  <= 4'd5;
         edly_ff  <= 4'd4;
      end else begin
         outst_ff  <= outst_in;
         issued_ff <= issued_in;
         head_ff   <= head_in;
         wait_ff   <= wait_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         wcnt_ff   <= wcnt_in;
         caddr_ff  <= caddr_in;
         crem_ff   <= crem_in;
         croff_ff  <= croff_in;
         stall_ff  <= stall_in;
         tok_ff    <= tok_in;
         tick_ff   <= tick_in;
         rcnt_ff   <= rcnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MAX_BURST:   maxb_ff <= csr_data;
               CSR_START_DELAY: sdly_ff <= csr_data[3:0];
               CSR_END_DELAY:   edly_ff <= csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ready_ff <= ready_in;
      res_ff   <= res_in;
      if (enq_wr) begin
         saddr_ff[tail_ff]  <= q_item.base_addr;
         sbytes_ff[tail_ff] <= q_item.bytes;
         swrite_ff[tail_ff] <= q_item.is_store;
         sroff_ff[tail_ff]  <= q_item.reg_offset;
      end
   end

   `VLS_ASSERT(a_tok_bound, tok_ff <= TOK_W'(BURST_TOKENS), "burst tokens above pool size")
   `VLS_ASSERT(a_wait_le_occ, wcnt_ff <= occ_ff, "more waiting than occupied slots")
   `VLS_ASSERT(a_rcnt_bound, rcnt_ff <= 2'd2, "result buffer overflow")
   `VLS_ASSERT_NEXT(a_pop_empties, q_pop && q_item.op == OP_DENY, rcnt_ff == 2'd0 && stall_ff, "deny left results or no stall")

endmodule
